>>> design/hvn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hvn_pkg - shared types and constants for the heightmap vertex normal block
// Item structs, sequencer states and fixed widths of the arithmetic.
// ----------------------------------------------------------------------------
package hvn_pkg;

	// configuration register indexes
	localparam logic [2:0] CFG_GRID_WIDTH   = 3'd0;
	localparam logic [2:0] CFG_GRID_HEIGHT  = 3'd1;
	localparam logic [2:0] CFG_EXTENT_X     = 3'd2;
	localparam logic [2:0] CFG_EXTENT_Z     = 3'd3;
	localparam logic [2:0] CFG_HEIGHT_SCALE = 3'd4;

	localparam logic [8:0]  DIM_RESET = 9'd256;
	localparam logic [15:0] Q88_ONE   = 16'd256;

	localparam int DIM_W     = 9;   // grid dimension width
	localparam int TOTAL_W   = 18;  // width of W*H
	localparam int NUM_FACES = 4;

	typedef struct packed {
		logic        action;
		logic [15:0] height_sample;
		logic [15:0] vertex_index;
	} in_item_t;

	typedef struct packed {
		logic [15:0]        pos_x;
		logic [31:0]        pos_y;
		logic [15:0]        pos_z;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic [15:0]        tex_u;
		logic [16:0]        tex_v;
	} out_item_t;

	// edge vector between two vertices
	typedef struct packed {
		logic signed [32:0] x;
		logic signed [32:0] y;
		logic signed [32:0] z;
	} vec3_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_XY,
		ST_RD,
		ST_POS_SET,
		ST_POS_DONE,
		ST_FACE,
		ST_CROSS,
		ST_N_ABS,
		ST_N_SHIFT,
		ST_N_SQ,
		ST_N_SQRT,
		ST_N_DSET,
		ST_N_DDONE,
		ST_N_END,
		ST_OUT
	} state_t;

endpackage
`default_nettype wire

>>> design/hvn_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hvn_ram - generic simple dual port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hvn_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> design/heightmap_vertex_normal_gen.sv
`default_nettype none
// ----------------------------------------------------------------------------
// heightmap_vertex_normal_gen - terrain vertex position, texture and normal
// Height grid store plus a sequenced fixed-point normal generator.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_stall/in_data): a load item (action 0) writes the
//   next height sample in raster order; a query item (action 1) names a vertex
//   by raster index. Loads run back to back while no query is in progress.
//   out channel (out_valid/out_stall/out_data): one item per in-range query,
//   none for loads or for an index at or past W*H. cfg port: cfg_we/cfg_addr/
//   cfg_data: the user writes only while the block is idle; it is not checked.
// Sequencing:
//   A query holds in_stall until it is done, so no new item is taken before
//   then. The work is set by the one shared 64-step restoring divider: 9
//   divides for index split, position and texture plus 3 per normalization
//   (one per existing face and one for the final sum), each normalization
//   also running the bit-pair square root.
// Reset: config registers return to 256, the load position to 0. The grid
//   store is not cleared; queries are meaningful only after a full grid load.
// Stall: a finished result sits in the output register; a new item is taken
//   meanwhile, and a later query waits at its end until that register frees.
// ----------------------------------------------------------------------------
module heightmap_vertex_normal_gen #(
	parameter int MAX_DIM = 256
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire hvn_pkg::in_item_t    in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output hvn_pkg::out_item_t        out_data,
	input  wire logic                 cfg_we,
	input  wire logic [2:0]           cfg_addr,
	input  wire logic [15:0]          cfg_data
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int LPW   = (AW > hvn_pkg::TOTAL_W) ? AW : hvn_pkg::TOTAL_W;

	// configuration
	logic [8:0]  grid_width_q, grid_height_q;
	logic [15:0] extent_x_q, extent_z_q, height_scale_q;

	// control
	hvn_pkg::state_t state_q, state_d, ret_q;
	logic [2:0]      k_q, k_d;
	logic [2:0]      face_q, face_d;
	logic [LPW-1:0]  lp_q;
	logic            out_valid_q;

	// query datapath
	logic [15:0] idx_q;
	logic [8:0]  x_q, y_q;
	logic [31:0] py_q [5];   // c0, right, left, down, up
	logic [15:0] px_m_q, px_0_q, px_p_q, pz_m_q, pz_0_q, pz_p_q, tu_q, tv_q;

	// shared divider
	logic [63:0] div_num_q;
	logic [31:0] div_rem_q, div_den_q;
	logic [5:0]  div_cnt_q;

	// normalizer
	logic signed [63:0] nv_q [3];
	logic [63:0]        m_q [3];
	logic               neg_q [3];
	logic               final_q;
	logic [63:0]        sq_n_q, sq_r_q, sq_bit_q;
	logic signed [29:0] nres_q [3];
	logic signed [31:0] acc_q [3];

	hvn_pkg::out_item_t out_q;

	// ---------------- grid size ----------------
	logic [8:0]                    w_eff, h_eff;
	logic [hvn_pkg::TOTAL_W-1:0]   total;
	logic [LPW-1:0]                total_lp, lp_base, lp_inc, lp_next;
	logic                          in_acc, do_load, in_range;

	always_comb begin
		if (grid_width_q == '0)
			w_eff = 9'd1;
		else if (32'(grid_width_q) > MAX_DIM)
			w_eff = 9'(MAX_DIM);
		else
			w_eff = grid_width_q;
		if (grid_height_q == '0)
			h_eff = 9'd1;
		else if (32'(grid_height_q) > MAX_DIM)
			h_eff = 9'(MAX_DIM);
		else
			h_eff = grid_height_q;
	end

	assign total    = hvn_pkg::TOTAL_W'(w_eff) * hvn_pkg::TOTAL_W'(h_eff);
	assign total_lp = LPW'(total);
	assign in_stall = (state_q != hvn_pkg::ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign do_load  = in_acc && !in_data.action;
	assign in_range = hvn_pkg::TOTAL_W'(in_data.vertex_index) < total;

	// load position wraps at W*H; a stale position past a shrunk grid restarts at 0
	assign lp_base = (lp_q >= total_lp) ? '0 : lp_q;
	assign lp_inc  = lp_base + LPW'(1);
	assign lp_next = (lp_inc >= total_lp) ? '0 : lp_inc;

	// ---------------- grid store ----------------
	logic [31:0]   rd_lin;
	logic [AW-1:0] raddr;
	logic [15:0]   ram_rdata;

	always_comb begin
		case (k_q)
			3'd1:    rd_lin = {16'd0, idx_q} + 32'd1;
			3'd2:    rd_lin = {16'd0, idx_q} - 32'd1;
			3'd3:    rd_lin = {16'd0, idx_q} + 32'(w_eff);
			3'd4:    rd_lin = {16'd0, idx_q} - 32'(w_eff);
			default: rd_lin = {16'd0, idx_q};
		endcase
	end
	assign raddr = rd_lin[AW-1:0];

	hvn_ram #(
		.WIDTH(16),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (do_load),
		.waddr(lp_base[AW-1:0]),
		.wdata(in_data.height_sample),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	// ---------------- neighbor flags ----------------
	logic hr, hl, hd, hu, face_ok;
	assign hr = (10'(x_q) + 10'd1) < 10'(w_eff);
	assign hl = (x_q != '0);
	assign hd = (10'(y_q) + 10'd1) < 10'(h_eff);
	assign hu = (y_q != '0);

	always_comb begin
		case (face_q[1:0])
			2'd0:    face_ok = hr && hd;
			2'd1:    face_ok = hr && hu;
			2'd2:    face_ok = hl && hu;
			default: face_ok = hl && hd;
		endcase
	end

	// ---------------- edges from center vertex ----------------
	// Right/left neighbors share z with the center, down/up share x.
	hvn_pkg::vec3_t e_r, e_l, e_d, e_u, ea, fb;
	logic signed [32:0] dx_r, dx_l, dz_d, dz_u;

	assign dx_r = ($signed({17'd0, px_p_q}) - $signed({17'd0, px_0_q})) <<< 8;
	assign dx_l = ($signed({17'd0, px_m_q}) - $signed({17'd0, px_0_q})) <<< 8;
	assign dz_d = ($signed({17'd0, pz_p_q}) - $signed({17'd0, pz_0_q})) <<< 8;
	assign dz_u = ($signed({17'd0, pz_m_q}) - $signed({17'd0, pz_0_q})) <<< 8;

	assign e_r = {dx_r, $signed({1'b0, py_q[1]}) - $signed({1'b0, py_q[0]}), 33'sd0};
	assign e_l = {dx_l, $signed({1'b0, py_q[2]}) - $signed({1'b0, py_q[0]}), 33'sd0};
	assign e_d = {33'sd0, $signed({1'b0, py_q[3]}) - $signed({1'b0, py_q[0]}), dz_d};
	assign e_u = {33'sd0, $signed({1'b0, py_q[4]}) - $signed({1'b0, py_q[0]}), dz_u};

	// faces in winding order: (down,right) (right,up) (up,left) (left,down)
	always_comb begin
		case (face_q[1:0])
			2'd0: begin
				ea = e_d;
				fb = e_r;
			end
			2'd1: begin
				ea = e_r;
				fb = e_u;
			end
			2'd2: begin
				ea = e_u;
				fb = e_l;
			end
			default: begin
				ea = e_l;
				fb = e_d;
			end
		endcase
	end

	// ---------------- position divide operands ----------------
	logic [9:0]  pos_coord;
	logic [16:0] pos_ext;
	logic [8:0]  pos_den;

	always_comb begin
		case (k_q)
			3'd0:    pos_coord = (x_q == '0) ? 10'd0 : 10'(x_q) - 10'd1;
			3'd1:    pos_coord = 10'(x_q);
			3'd2:    pos_coord = 10'(x_q) + 10'd1;
			3'd3:    pos_coord = (y_q == '0) ? 10'd0 : 10'(y_q) - 10'd1;
			3'd4:    pos_coord = 10'(y_q);
			3'd5:    pos_coord = 10'(y_q) + 10'd1;
			3'd6:    pos_coord = 10'(x_q);
			default: pos_coord = 10'(y_q);
		endcase
		case (k_q)
			3'd0, 3'd1, 3'd2: pos_ext = {1'b0, extent_x_q};
			3'd3, 3'd4, 3'd5: pos_ext = {1'b0, extent_z_q};
			default:          pos_ext = 17'h10000;   // texture: coord << 16
		endcase
		case (k_q)
			3'd0, 3'd1, 3'd2, 3'd6: pos_den = w_eff;
			default:                pos_den = h_eff;
		endcase
	end

	// ---------------- normalizer helpers ----------------
	logic [63:0] m_sel;
	logic        big;
	logic [63:0] sq_t;
	logic        sq_ge;

	assign m_sel = m_q[k_q[1:0]];
	assign big   = (|m_q[0][63:30]) || (|m_q[1][63:30]) || (|m_q[2][63:30]);
	assign sq_t  = sq_r_q + sq_bit_q;
	assign sq_ge = sq_n_q >= sq_t;

	// ---------------- shared multiplier ----------------
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			hvn_pkg::ST_RD: begin
				mul_a = $signed({17'd0, ram_rdata});
				mul_b = $signed({17'd0, height_scale_q});
			end
			hvn_pkg::ST_POS_SET: begin
				mul_a = $signed({23'd0, pos_coord});
				mul_b = $signed({16'd0, pos_ext});
			end
			hvn_pkg::ST_CROSS: begin
				case (k_q)
					3'd0: begin
						mul_a = ea.y;
						mul_b = fb.z;
					end
					3'd1: begin
						mul_a = ea.z;
						mul_b = fb.y;
					end
					3'd2: begin
						mul_a = ea.z;
						mul_b = fb.x;
					end
					3'd3: begin
						mul_a = ea.x;
						mul_b = fb.z;
					end
					3'd4: begin
						mul_a = ea.x;
						mul_b = fb.y;
					end
					default: begin
						mul_a = ea.y;
						mul_b = fb.x;
					end
				endcase
			end
			hvn_pkg::ST_N_SQ: begin
				mul_a = $signed({3'd0, m_sel[29:0]});
				mul_b = $signed({3'd0, m_sel[29:0]});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// ---------------- divider step ----------------
	logic [32:0] div_trial, div_sub;
	logic        div_ge;
	logic [31:0] div_rem_nx;

	assign div_trial  = {div_rem_q, div_num_q[63]};
	assign div_ge     = div_trial >= {1'b0, div_den_q};
	assign div_sub    = div_trial - {1'b0, div_den_q};
	assign div_rem_nx = div_ge ? div_sub[31:0] : div_trial[31:0];

	logic [28:0]        nq;
	logic signed [29:0] nq_signed;
	assign nq        = (sq_r_q == '0) ? '0 : div_num_q[28:0];
	assign nq_signed = neg_q[k_q[1:0]] ? -$signed({1'b0, nq}) : $signed({1'b0, nq});

	// ---------------- sequencer next state ----------------
	always_comb begin
		state_d = state_q;
		k_d     = k_q;
		face_d  = face_q;
		case (state_q)
			hvn_pkg::ST_IDLE: begin
				if (in_acc && in_data.action && in_range)
					state_d = hvn_pkg::ST_DIV;
			end
			hvn_pkg::ST_DIV: begin
				if (div_cnt_q == 6'd63)
					state_d = ret_q;
			end
			hvn_pkg::ST_XY: begin
				state_d = hvn_pkg::ST_RD;
				k_d     = '0;
			end
			hvn_pkg::ST_RD: begin
				if (k_q == 3'd5) begin
					state_d = hvn_pkg::ST_POS_SET;
					k_d     = '0;
				end else begin
					k_d = k_q + 3'd1;
				end
			end
			hvn_pkg::ST_POS_SET: begin
				state_d = hvn_pkg::ST_DIV;
			end
			hvn_pkg::ST_POS_DONE: begin
				if (k_q == 3'd7) begin
					state_d = hvn_pkg::ST_FACE;
					face_d  = '0;
				end else begin
					state_d = hvn_pkg::ST_POS_SET;
					k_d     = k_q + 3'd1;
				end
			end
			hvn_pkg::ST_FACE: begin
				if (face_q == 3'(hvn_pkg::NUM_FACES)) begin
					state_d = hvn_pkg::ST_N_ABS;
				end else if (face_ok) begin
					state_d = hvn_pkg::ST_CROSS;
					k_d     = '0;
				end else begin
					face_d = face_q + 3'd1;
				end
			end
			hvn_pkg::ST_CROSS: begin
				if (k_q == 3'd5)
					state_d = hvn_pkg::ST_N_ABS;
				else
					k_d = k_q + 3'd1;
			end
			hvn_pkg::ST_N_ABS: begin
				state_d = hvn_pkg::ST_N_SHIFT;
			end
			hvn_pkg::ST_N_SHIFT: begin
				if (!big) begin
					state_d = hvn_pkg::ST_N_SQ;
					k_d     = '0;
				end
			end
			hvn_pkg::ST_N_SQ: begin
				if (k_q == 3'd2)
					state_d = hvn_pkg::ST_N_SQRT;
				else
					k_d = k_q + 3'd1;
			end
			hvn_pkg::ST_N_SQRT: begin
				if (sq_bit_q[0]) begin
					state_d = hvn_pkg::ST_N_DSET;
					k_d     = '0;
				end
			end
			hvn_pkg::ST_N_DSET: begin
				state_d = hvn_pkg::ST_DIV;
			end
			hvn_pkg::ST_N_DDONE: begin
				if (k_q == 3'd2) begin
					state_d = hvn_pkg::ST_N_END;
				end else begin
					state_d = hvn_pkg::ST_N_DSET;
					k_d     = k_q + 3'd1;
				end
			end
			hvn_pkg::ST_N_END: begin
				if (final_q) begin
					state_d = hvn_pkg::ST_OUT;
				end else begin
					state_d = hvn_pkg::ST_FACE;
					face_d  = face_q + 3'd1;
				end
			end
			hvn_pkg::ST_OUT: begin
				if (!out_valid_q || !out_stall)
					state_d = hvn_pkg::ST_IDLE;
			end
			default: state_d = hvn_pkg::ST_IDLE;
		endcase
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= hvn_pkg::ST_IDLE;
			k_q            <= '0;
			face_q         <= '0;
			lp_q           <= '0;
			out_valid_q    <= 1'b0;
			grid_width_q   <= hvn_pkg::DIM_RESET;
			grid_height_q  <= hvn_pkg::DIM_RESET;
			extent_x_q     <= hvn_pkg::Q88_ONE;
			extent_z_q     <= hvn_pkg::Q88_ONE;
			height_scale_q <= hvn_pkg::Q88_ONE;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			face_q  <= face_d;
			if (do_load)
				lp_q <= lp_next;
			if (state_q == hvn_pkg::ST_OUT && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_addr)
					hvn_pkg::CFG_GRID_WIDTH:   grid_width_q   <= cfg_data[8:0];
					hvn_pkg::CFG_GRID_HEIGHT:  grid_height_q  <= cfg_data[8:0];
					hvn_pkg::CFG_EXTENT_X:     extent_x_q     <= cfg_data;
					hvn_pkg::CFG_EXTENT_Z:     extent_z_q     <= cfg_data;
					hvn_pkg::CFG_HEIGHT_SCALE: height_scale_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		case (state_q)
			hvn_pkg::ST_IDLE: begin
				// first divide splits the index into row and column
				idx_q     <= in_data.vertex_index;
				div_num_q <= 64'(in_data.vertex_index);
				div_den_q <= 32'(w_eff);
				div_rem_q <= '0;
				div_cnt_q <= '0;
				ret_q     <= hvn_pkg::ST_XY;
			end
			hvn_pkg::ST_DIV: begin
				div_num_q <= {div_num_q[62:0], div_ge};
				div_rem_q <= div_rem_nx;
				div_cnt_q <= div_cnt_q + 6'd1;
			end
			hvn_pkg::ST_XY: begin
				x_q <= div_rem_q[8:0];
				y_q <= div_num_q[8:0];
				for (int i = 0; i < 3; i++)
					acc_q[i] <= '0;
			end
			hvn_pkg::ST_RD: begin
				if (k_q != '0)
					py_q[k_q - 3'd1] <= mul_p[31:0];
			end
			hvn_pkg::ST_POS_SET: begin
				div_num_q <= mul_p[63:0];
				div_den_q <= 32'(pos_den);
				div_rem_q <= '0;
				div_cnt_q <= '0;
				ret_q     <= hvn_pkg::ST_POS_DONE;
			end
			hvn_pkg::ST_POS_DONE: begin
				case (k_q)
					3'd0:    px_m_q <= div_num_q[15:0];
					3'd1:    px_0_q <= div_num_q[15:0];
					3'd2:    px_p_q <= div_num_q[15:0];
					3'd3:    pz_m_q <= div_num_q[15:0];
					3'd4:    pz_0_q <= div_num_q[15:0];
					3'd5:    pz_p_q <= div_num_q[15:0];
					3'd6:    tu_q   <= div_num_q[15:0];
					default: tv_q   <= div_num_q[15:0];
				endcase
			end
			hvn_pkg::ST_FACE: begin
				if (face_q == 3'(hvn_pkg::NUM_FACES)) begin
					for (int i = 0; i < 3; i++)
						nv_q[i] <= 64'(acc_q[i]);
					final_q <= 1'b1;
				end else begin
					final_q <= 1'b0;
				end
			end
			hvn_pkg::ST_CROSS: begin
				case (k_q)
					3'd0:    nv_q[0] <= mul_p[63:0];
					3'd1:    nv_q[0] <= nv_q[0] - mul_p[63:0];
					3'd2:    nv_q[1] <= mul_p[63:0];
					3'd3:    nv_q[1] <= nv_q[1] - mul_p[63:0];
					3'd4:    nv_q[2] <= mul_p[63:0];
					default: nv_q[2] <= nv_q[2] - mul_p[63:0];
				endcase
			end
			hvn_pkg::ST_N_ABS: begin
				for (int i = 0; i < 3; i++) begin
					neg_q[i] <= nv_q[i][63];
					m_q[i]   <= nv_q[i][63] ? (64'd0 - nv_q[i]) : nv_q[i];
				end
			end
			hvn_pkg::ST_N_SHIFT: begin
				// bring all magnitudes under 2^30, one bit a cycle
				if (big) begin
					for (int i = 0; i < 3; i++)
						m_q[i] <= m_q[i] >> 1;
				end
				sq_r_q   <= '0;
				sq_bit_q <= 64'd1 << 62;
			end
			hvn_pkg::ST_N_SQ: begin
				sq_n_q <= ((k_q == '0) ? 64'd0 : sq_n_q) + mul_p[63:0];
			end
			hvn_pkg::ST_N_SQRT: begin
				if (sq_ge) begin
					sq_n_q <= sq_n_q - sq_t;
					sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
				end else begin
					sq_r_q <= sq_r_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
			end
			hvn_pkg::ST_N_DSET: begin
				div_num_q <= final_q ? {20'd0, m_sel[29:0], 14'd0}
				                     : {6'd0, m_sel[29:0], 28'd0};
				div_den_q <= sq_r_q[31:0];
				div_rem_q <= '0;
				div_cnt_q <= '0;
				ret_q     <= hvn_pkg::ST_N_DDONE;
			end
			hvn_pkg::ST_N_DDONE: begin
				// zero length gives a zero component
				nres_q[k_q[1:0]] <= nq_signed;
			end
			hvn_pkg::ST_N_END: begin
				if (!final_q) begin
					for (int i = 0; i < 3; i++)
						acc_q[i] <= acc_q[i] + 32'(nres_q[i]);
				end
			end
			hvn_pkg::ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					out_q.pos_x    <= px_0_q;
					out_q.pos_y    <= py_q[0];
					out_q.pos_z    <= pz_0_q;
					out_q.normal_x <= nres_q[0][15:0];
					out_q.normal_y <= nres_q[1][15:0];
					out_q.normal_z <= nres_q[2][15:0];
					out_q.tex_u    <= tu_q;
					out_q.tex_v    <= 17'h10000 - {1'b0, tv_q};
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - heightmap vertex normal generator
// Loads small height grids, queries vertices and checks position, texture
// coordinates and unit normal of every result against a fixed-point predictor
// kept inside the bench. Runs directed corner cases, then random grids under
// several patterns of input gaps and output stalls.
// ----------------------------------------------------------------------------
module testbench;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;
	localparam int   MAX_DIM   = 256;
	localparam int   SETTLE    = 2500;	// worst query latency plus margin

	typedef struct packed {
		logic signed [63:0] x;
		logic signed [63:0] y;
		logic signed [63:0] z;
	} v3_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	hvn_pkg::in_item_t  in_data;
	logic               out_valid;
	logic               out_stall;
	hvn_pkg::out_item_t out_data;
	logic               cfg_we;
	logic [2:0]         cfg_addr;
	logic [15:0]        cfg_data;

	// bench copy of block state
	logic [8:0]  grid_w, grid_h;
	logic [15:0] ext_x, ext_z, h_scale;
	logic [15:0] height_mem [0:65535];
	int          load_pos;

	hvn_pkg::out_item_t vertex_q[$];	// vertex results still to arrive
	int        err_cnt;
	int        gap_pct;			// chance in 100 that the sender idles a cycle
	int        stall_pct;		// chance in 100 that the receiver stalls a cycle

	heightmap_vertex_normal_gen u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// ------------------------------------------------------------------
	// fixed-point normal arithmetic
	// ------------------------------------------------------------------
	function automatic logic [63:0] isqrt(logic [63:0] n);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// scale to unit length with frac fraction bits, truncating; zero stays zero
	function automatic v3_t unit_vec(v3_t c, int frac);
		logic signed [63:0] cc [3];
		logic [63:0] m [3];
		logic [63:0] mx, n2, len, q;
		logic        neg [3];
		int          s, i;
		v3_t         o;
		cc[0] = c.x;
		cc[1] = c.y;
		cc[2] = c.z;
		mx = 0;
		s = 0;
		for (i = 0; i < 3; i++) begin
			neg[i] = cc[i] < 0;
			m[i] = neg[i] ? 64'd0 - cc[i] : cc[i];
			if (m[i] > mx)
				mx = m[i];
		end
		// bring every component under 2^30 so the squares fit
		while (s < 63 && (mx >> s) >= (64'd1 << 30))
			s++;
		for (i = 0; i < 3; i++)
			m[i] = m[i] >> s;
		n2 = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
		len = isqrt(n2);
		for (i = 0; i < 3; i++) begin
			q = (len == 0) ? 64'd0 : (m[i] << frac) / len;
			cc[i] = neg[i] ? -$signed(q) : $signed(q);
		end
		o.x = cc[0];
		o.y = cc[1];
		o.z = cc[2];
		return o;
	endfunction

	// vertex position: x,z in Q8.16, y as the raw Q16.16 product
	function automatic v3_t vert_at(int x, int y, int w, int h);
		logic [63:0] px, pz;
		v3_t         o;
		px = (64'(x) * ext_x) / w;
		pz = (64'(y) * ext_z) / h;
		o.x = px * 256;
		o.y = 64'(height_mem[(y * w + x) & 16'hFFFF]) * h_scale;
		o.z = pz * 256;
		return o;
	endfunction

	function automatic v3_t face_unit(v3_t c0, v3_t a, v3_t b);
		v3_t e, f, x;
		e.x = a.x - c0.x;
		e.y = a.y - c0.y;
		e.z = a.z - c0.z;
		f.x = b.x - c0.x;
		f.y = b.y - c0.y;
		f.z = b.z - c0.z;
		x.x = e.y * f.z - e.z * f.y;
		x.y = e.z * f.x - e.x * f.z;
		x.z = e.x * f.y - e.y * f.x;
		return unit_vec(x, 28);
	endfunction

	function automatic int eff_dim(logic [8:0] r);
		if (r == 0)
			return 1;
		if (r > MAX_DIM)
			return MAX_DIM;
		return int'(r);
	endfunction

	// update the bench state for one accepted item, queue the result of an in-range query
	task automatic predict_vertex(hvn_pkg::in_item_t it);
		int          w, h, total, idx, x, y;
		logic        hr, hl, hd, hu;
		v3_t         c0, vr, vl, vd, vu, acc, u, n;
		logic [63:0] tu, tv;
		hvn_pkg::out_item_t ex;
		w = eff_dim(grid_w);
		h = eff_dim(grid_h);
		total = w * h;
		if (it.action == ACT_LOAD) begin
			// a shrunken grid can leave the pointer past the end
			if (load_pos >= total)
				load_pos = 0;
			height_mem[load_pos & 16'hFFFF] = it.height_sample;
			load_pos++;
			if (load_pos >= total)
				load_pos = 0;
			return;
		end
		idx = int'(it.vertex_index);
		if (idx >= total)
			return;
		x = idx % w;
		y = idx / w;
		c0 = vert_at(x, y, w, h);
		hr = x + 1 < w;
		hl = x > 0;
		hd = y + 1 < h;
		hu = y > 0;
		if (hr) vr = vert_at(x + 1, y, w, h);
		if (hl) vl = vert_at(x - 1, y, w, h);
		if (hd) vd = vert_at(x, y + 1, w, h);
		if (hu) vu = vert_at(x, y - 1, w, h);
		acc = '0;
		// four quadrant faces around the vertex, each only where both edges exist
		for (int fc = 0; fc < hvn_pkg::NUM_FACES; fc++) begin
			u = '0;
			case (fc)
				0: if (hr && hd) u = face_unit(c0, vd, vr);
				1: if (hr && hu) u = face_unit(c0, vr, vu);
				2: if (hl && hu) u = face_unit(c0, vu, vl);
				default: if (hl && hd) u = face_unit(c0, vl, vd);
			endcase
			acc.x = acc.x + u.x;
			acc.y = acc.y + u.y;
			acc.z = acc.z + u.z;
		end
		n = unit_vec(acc, 14);
		tu = (64'(x) << 16) / w;
		tv = 64'd65536 - ((64'(y) << 16) / h);
		ex.pos_x    = c0.x[23:8];
		ex.pos_y    = c0.y[31:0];
		ex.pos_z    = c0.z[23:8];
		ex.normal_x = n.x[15:0];
		ex.normal_y = n.y[15:0];
		ex.normal_z = n.z[15:0];
		ex.tex_u    = tu[15:0];
		ex.tex_v    = tv[16:0];
		vertex_q = {vertex_q, ex};
	endtask

	// ------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------
	function automatic void check_field(string name, logic [31:0] ev, logic [31:0] av);
		if (ev !== av) begin
			err_cnt++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, ev, av);
		end
	endfunction

	always @(posedge clk) begin
		hvn_pkg::out_item_t ex;
		if (arst_n && out_valid && !out_stall) begin
			if (vertex_q.size() == 0) begin
				err_cnt++;
				$display("%0t: unexpected result, expected none, got %h",
					$time, out_data);
			end else begin
				ex = vertex_q.pop_front();
				check_field("pos_x",    32'(ex.pos_x),    32'(out_data.pos_x));
				check_field("pos_y",    ex.pos_y,         out_data.pos_y);
				check_field("pos_z",    32'(ex.pos_z),    32'(out_data.pos_z));
				check_field("normal_x", 32'(ex.normal_x), 32'(out_data.normal_x));
				check_field("normal_y", 32'(ex.normal_y), 32'(out_data.normal_y));
				check_field("normal_z", 32'(ex.normal_z), 32'(out_data.normal_z));
				check_field("tex_u",    32'(ex.tex_u),    32'(out_data.tex_u));
				check_field("tex_v",    32'(ex.tex_v),    32'(out_data.tex_v));
			end
		end
	end

	// receiver back-pressure, changed at the falling edge
	always @(negedge clk)
		out_stall = ($urandom_range(99) < stall_pct);

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	// valid stays high after acceptance so back-to-back items keep it up
	task automatic send_item(hvn_pkg::in_item_t it);
		logic taken;
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			in_valid = 1'b0;
			in_data = 33'({$urandom, $urandom});
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data = it;
		taken = 1'b0;
		while (!taken) begin
			#1;
			taken = !in_stall;
			@(posedge clk);
			if (!taken)
				@(negedge clk);
		end
		predict_vertex(it);
	endtask

	task automatic load_height(logic [15:0] hv);
		hvn_pkg::in_item_t it;
		it.action = ACT_LOAD;
		it.height_sample = hv;
		it.vertex_index = 16'($urandom);
		send_item(it);
	endtask

	task automatic query_vertex(logic [15:0] idx);
		hvn_pkg::in_item_t it;
		it.action = ACT_QUERY;
		it.height_sample = 16'($urandom);
		it.vertex_index = idx;
		send_item(it);
	endtask

	// drop valid, drain every result, then let any silent work finish
	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		wait (vertex_q.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] addr, logic [15:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_addr = addr;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (addr)
			hvn_pkg::CFG_GRID_WIDTH:  grid_w = val[8:0];
			hvn_pkg::CFG_GRID_HEIGHT: grid_h = val[8:0];
			hvn_pkg::CFG_EXTENT_X:    ext_x = val;
			hvn_pkg::CFG_EXTENT_Z:    ext_z = val;
			default:                  h_scale = val;
		endcase
	endtask

	task automatic set_grid(logic [8:0] w, logic [8:0] h, logic [15:0] ex,
			logic [15:0] ez, logic [15:0] hs);
		write_reg(hvn_pkg::CFG_GRID_WIDTH, 16'(w));
		write_reg(hvn_pkg::CFG_GRID_HEIGHT, 16'(h));
		write_reg(hvn_pkg::CFG_EXTENT_X, ex);
		write_reg(hvn_pkg::CFG_EXTENT_Z, ez);
		write_reg(hvn_pkg::CFG_HEIGHT_SCALE, hs);
	endtask

	// biased toward the field extremes
	function automatic logic [15:0] pick16();
		int r;
		r = $urandom_range(99);
		if (r < 12)
			return 16'h0000;
		if (r < 24)
			return 16'hFFFF;
		return 16'($urandom);
	endfunction

	task automatic fill_grid();
		int total;
		total = eff_dim(grid_w) * eff_dim(grid_h);
		for (int i = 0; i < total; i++)
			load_height(pick16());
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	// corners and interior of a 4x3 grid with extreme values
	task automatic test_corners();
		logic [15:0] hv [12];
		hv = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h0100, 16'hFFFF,
			16'h0000, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE, 16'h1234};
		set_grid(9'd4, 9'd3, 16'hFFFF, 16'h0000, 16'hFFFF);
		foreach (hv[i])
			load_height(hv[i]);
		query_vertex(16'd0);
		query_vertex(16'd3);
		query_vertex(16'd5);
		query_vertex(16'd8);
		query_vertex(16'd11);
		query_vertex(16'd12);		// one past the end: dropped
		query_vertex(16'hFFFF);		// far out of range: dropped
		wait_idle();
	endtask

	// zero extents flatten every edge onto y, so all faces vanish
	task automatic test_zero_normal();
		set_grid(9'd3, 9'd3, 16'h0000, 16'h0000, 16'h0100);
		for (int i = 0; i < 9; i++)
			load_height(16'(i * 4000));
		query_vertex(16'd4);
		query_vertex(16'd0);
		wait_idle();
	endtask

	// size registers of 0 and above the maximum, single rows and columns
	task automatic test_degenerate_sizes();
		set_grid(9'd0, 9'd5, 16'h0100, 16'hFFFF, 16'h0100);	// one column
		fill_grid();
		query_vertex(16'd0);
		query_vertex(16'd4);
		wait_idle();
		set_grid(9'd511, 9'd0, 16'hFFFF, 16'h0100, 16'h8000);	// 256 by 1
		fill_grid();
		query_vertex(16'd0);
		query_vertex(16'd255);
		query_vertex(16'd256);
		wait_idle();
		set_grid(9'd1, 9'd256, 16'h0100, 16'h0100, 16'h0100);	// 1 by 256
		fill_grid();
		query_vertex(16'd128);
		wait_idle();
	endtask

	// stored samples survive a resize; a stale load pointer restarts at 0
	task automatic test_resize();
		set_grid(9'd6, 9'd6, 16'h0300, 16'h0200, 16'h0180);
		fill_grid();
		for (int i = 0; i < 25; i++)
			load_height(pick16());
		wait_idle();
		set_grid(9'd4, 9'd5, 16'h0100, 16'h0400, 16'h0100);
		query_vertex(16'd6);
		query_vertex(16'd19);
		load_height(16'hBEEF);
		query_vertex(16'd1);
		wait_idle();
	endtask

	// random grids and queries under one idling pattern
	task automatic test_random(int gp, int sp, int rounds);
		int r, nq, w, h, total;
		logic [8:0] gw, gh;
		gap_pct = gp;
		stall_pct = sp;
		for (int k = 0; k < rounds; k++) begin
			r = $urandom_range(99);
			if (r < 80) begin
				gw = 9'($urandom_range(8, 1));
				gh = 9'($urandom_range(8, 1));
			end else if (r < 93) begin
				gw = 9'($urandom_range(16, 1));
				gh = 9'($urandom_range(16, 1));
			end else begin
				// raw register values of 0 or at or above the maximum; height 0 or 1 gives one row
				gw = $urandom_range(1) ? 9'd0 : 9'($urandom_range(511, 256));
				gh = $urandom_range(1) ? 9'd0 : 9'd1;
			end
			set_grid(gw, gh, pick16(), pick16(), pick16());
			fill_grid();
			w = eff_dim(gw);
			h = eff_dim(gh);
			total = w * h;
			nq = $urandom_range(10, 6);
			for (int q = 0; q < nq; q++) begin
				if ($urandom_range(99) < 10)
					query_vertex(16'($urandom));
				else
					query_vertex(16'($urandom_range(total - 1)));
			end
			wait_idle();
		end
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		err_cnt = 0;
		gap_pct = 0;
		stall_pct = 0;
		load_pos = 0;
		grid_w = hvn_pkg::DIM_RESET;
		grid_h = hvn_pkg::DIM_RESET;
		ext_x = hvn_pkg::Q88_ONE;
		ext_z = hvn_pkg::Q88_ONE;
		h_scale = hvn_pkg::Q88_ONE;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_addr = hvn_pkg::CFG_GRID_WIDTH;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_corners();
		test_zero_normal();
		test_degenerate_sizes();
		test_resize();
		test_random(0, 0, 4);
		test_random(69, 0, 4);
		test_random(0, 69, 4);
		test_random(21, 21, 4);

		if (err_cnt == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	// watchdog well above the slowest correct run
	initial begin
		#150_000_000;
		$display("testbench NOT OK");
		$finish;
	end

endmodule

>>> files.f
design/hvn_pkg.sv
design/hvn_ram.sv
design/heightmap_vertex_normal_gen.sv
tb/testbench.sv
